// ----- design/rff_pkg.sv -----
// ----------------------------------------------------------------------------
// rff_pkg
// Shared types, constants and helpers for the radial force field block.
// ----------------------------------------------------------------------------
package rff_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic [30:0] ONE_Q  = 31'(1) << FRAC_BITS;
	localparam logic [30:0] RMIN_Q = ((ONE_Q / 100) != 0) ? 31'(ONE_Q / 100) : 31'(1);
	localparam logic [30:0] RADIUS_RST = 31'd65536;
	localparam logic [31:0] STRENGTH_RST = 32'd65536;

	// wide enough for velocity plus a full-size velocity change
	localparam int RES_W = 64 - FRAC_BITS + 2;

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_RADIUS   = 3'd3;
	localparam logic [2:0] REG_STRENGTH = 3'd4;
	localparam logic [2:0] REG_IMPULSE  = 3'd5;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHK,
		ST_D0,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_D4,
		ST_CMP,
		ST_FALL,
		ST_MAG,
		ST_MAG2,
		ST_SQRT,
		ST_FM,
		ST_FM2,
		ST_FMW,
		ST_DV,
		ST_RES,
		ST_FIN
	} rff_state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] rem;
		logic [63:0] num;
		logic [63:0] den;
		logic [6:0]  steps;
	} div_req_t;

	function automatic logic [31:0] sat32(input logic signed [RES_W-1:0] v);
		logic [31:0] r;
		if (v > $signed(RES_W'(32'sh7FFFFFFF)))
			r = 32'h7FFFFFFF;
		else if (v < -$signed(RES_W'(33'sh080000000)))
			r = 32'h80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- design/rff_mul.sv -----
// ----------------------------------------------------------------------------
// rff_mul
// Shared 32x32 unsigned multiplier, product registered.
// ----------------------------------------------------------------------------
module rff_mul
	import rff_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule

// ----- design/rff_div.sv -----
// ----------------------------------------------------------------------------
// rff_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rff_div
	import rff_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done_q,
	output logic [63:0] quot_q
);

	logic [63:0] rem_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [63:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q[62:0], num_q[63]};
	assign ge     = rem_sh >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem;
			num_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sh - den_q : rem_sh;
			num_q  <= {num_q[62:0], 1'b0};
			quot_q <= {quot_q[62:0], ge};
		end
	end

endmodule

// ----- design/rff_sqrt.sv -----
// ----------------------------------------------------------------------------
// rff_sqrt
// Digit-by-digit integer square root of a 64-bit value.
// ----------------------------------------------------------------------------
module rff_sqrt
	import rff_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done_q,
	output logic [31:0] root
);

	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [63:0] t;
	logic        ge;

	assign t    = res_q + bit_q;
	assign ge   = x_q >= t;
	assign root = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			res_q <= '0;
			bit_q <= 64'(1) << 62;
		end else if (busy_q) begin
			if (ge) begin
				x_q   <= x_q - t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ----- design/radial_force_field.sv -----
// ----------------------------------------------------------------------------
// radial_force_field
// Radial force field with quadratic falloff, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One rigid body per request on the s_ side; one result per body on the m_
// side. Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user
// must do so only while the block is idle; the block does not enforce it.
// A body is worked on by a sequencer around one shared multiplier, one
// shift-subtract divider and one square-root unit; s_tready is high only in
// idle. Skipped bodies and bodies outside the radius on one axis go from the
// check straight to the result; bodies outside by distance stop after the
// squared-distance compare. Bodies inside run the falloff division, the root
// and three components, each mostly a 64-step division; at the center both
// divisions are skipped. The next request is taken once back in idle.
// The result waits in an output register; the next body may be accepted
// while it waits, and a finished body holds in the last step until the
// receiver takes the previous result.
// Reset clears configuration to its defaults, the impulse-fired flag and
// all handshake state. In impulse mode the block fires once, then answers
// every body with applied = 0 until reset.
// ----------------------------------------------------------------------------
module radial_force_field
	import rff_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, inv_mass
	input  logic [223:0] s_tdata,
	// kinematic, awake, mass_positive
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z
	output logic [95:0]  m_tdata,
	// applied, is_velocity
	output logic [1:0]   m_tuser
);

	rff_state_t state_q, state_d;

	logic signed [31:0] center_q [3];
	logic [30:0]        radius_q;
	logic signed [31:0] strength_q;
	logic               impulse_mode_q;
	logic               fired_q;

	logic signed [32:0] dc_q [3];
	logic [30:0]        adc_q [3];
	logic [32:0]        adc_w [3];
	logic signed [31:0] vel_q [3];
	logic [31:0]        inv_q;
	logic               skip_q;
	logic [63:0]        d2_q;
	logic [63:0]        r2_q;
	logic [FRAC_BITS:0] f_q;
	logic [31:0]        m_q;
	logic [30:0]        d_q;
	logic [31:0]        fm_q;
	logic [1:0]         k_q;
	logic [31:0]        res_q [3];
	logic               out_valid_q;
	logic [95:0]        out_data_q;
	logic [1:0]         out_user_q;

	logic [30:0] r_eff;
	logic        out_free;
	logic        outside;
	logic [31:0] mul_a, mul_b;
	logic [63:0] p_q;
	div_req_t    div_req;
	logic        div_done;
	logic [63:0] quot;
	logic        sq_start;
	logic        sq_done;
	logic [31:0] root;
	logic [31:0] str_mag;
	logic        neg;
	logic signed [RES_W-1:0] mag_w, sgn_w, sum_w;

	assign r_eff    = (radius_q < RMIN_Q) ? RMIN_Q : radius_q;
	assign out_free = !out_valid_q || m_tready;
	assign str_mag  = strength_q[31] ? 32'(-strength_q) : 32'(strength_q);

	always_comb begin
		for (int i = 0; i < 3; i++)
			adc_w[i] = dc_q[i][32] ? 33'(-dc_q[i]) : 33'(dc_q[i]);
	end

	assign outside = (adc_w[0] > 33'(r_eff)) || (adc_w[1] > 33'(r_eff)) ||
		(adc_w[2] > 33'(r_eff));

	rff_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(p_q));

	rff_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .done_q(div_done),
		.quot_q(quot));

	rff_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start), .x(d2_q),
		.done_q(sq_done), .root(root));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_CHK;
			ST_CHK:  state_d = (skip_q || outside) ? ST_FIN : ST_D0;
			ST_D0:   state_d = ST_D1;
			ST_D1:   state_d = ST_D2;
			ST_D2:   state_d = ST_D3;
			ST_D3:   state_d = ST_D4;
			ST_D4:   state_d = ST_CMP;
			ST_CMP: begin
				if (d2_q > r2_q)
					state_d = ST_FIN;
				else if (d2_q == 64'd0)
					state_d = ST_MAG;
				else
					state_d = ST_FALL;
			end
			ST_FALL: if (div_done) state_d = ST_MAG;
			ST_MAG:  state_d = ST_MAG2;
			ST_MAG2: state_d = ST_SQRT;
			ST_SQRT: if (sq_done) state_d = ST_FM;
			ST_FM:   state_d = (d_q == 31'd0) ? ST_DV : ST_FM2;
			ST_FM2:  state_d = ST_FMW;
			ST_FMW:  if (div_done) state_d = ST_DV;
			ST_DV:   state_d = ST_RES;
			ST_RES:  state_d = (k_q == 2'd2) ? ST_FIN : ST_FM;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		s_tready      = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		div_req       = '0;
		sq_start      = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_D0: begin
				mul_a = 32'(adc_q[0]);
				mul_b = 32'(adc_q[0]);
			end
			ST_D1: begin
				mul_a = 32'(adc_q[1]);
				mul_b = 32'(adc_q[1]);
			end
			ST_D2: begin
				mul_a = 32'(adc_q[2]);
				mul_b = 32'(adc_q[2]);
			end
			ST_D3: begin
				mul_a = 32'(r_eff);
				mul_b = 32'(r_eff);
			end
			ST_CMP: begin
				div_req.start = (d2_q <= r2_q) && (d2_q != 64'd0);
				div_req.rem   = r2_q - d2_q;
				div_req.den   = r2_q;
				div_req.steps = 7'(FRAC_BITS);
			end
			ST_MAG: begin
				mul_a = str_mag;
				mul_b = 32'(f_q);
			end
			ST_MAG2: sq_start = 1'b1;
			ST_FM: begin
				mul_a = m_q;
				mul_b = 32'(adc_q[k_q]);
			end
			ST_FM2: begin
				div_req.start = 1'b1;
				div_req.num   = p_q;
				div_req.den   = 64'(d_q);
				div_req.steps = 7'd64;
			end
			ST_DV: begin
				mul_a = fm_q;
				mul_b = inv_q;
			end
			default: ;
		endcase
	end

	assign neg   = dc_q[k_q][32] ^ strength_q[31];
	assign mag_w = impulse_mode_q ? $signed(RES_W'(p_q[63:FRAC_BITS])) :
		$signed(RES_W'(fm_q));
	assign sgn_w = neg ? -mag_w : mag_w;
	assign sum_w = impulse_mode_q ? sgn_w + RES_W'(vel_q[k_q]) : sgn_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			center_q[0]    <= '0;
			center_q[1]    <= '0;
			center_q[2]    <= '0;
			radius_q       <= RADIUS_RST;
			strength_q     <= STRENGTH_RST;
			impulse_mode_q <= 1'b0;
			fired_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_CENTER_X: center_q[0]    <= cfg_wdata;
					REG_CENTER_Y: center_q[1]    <= cfg_wdata;
					REG_CENTER_Z: center_q[2]    <= cfg_wdata;
					REG_RADIUS:   radius_q       <= cfg_wdata[30:0];
					REG_STRENGTH: strength_q     <= cfg_wdata;
					REG_IMPULSE:  impulse_mode_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
				if (!skip_q && impulse_mode_q)
					fired_q <= 1'b1;
			end else if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					dc_q[i]  <= $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]}) -
						$signed({center_q[i][31], center_q[i]});
					vel_q[i] <= s_tdata[96+32*i +: 32];
					res_q[i] <= '0;
				end
				inv_q  <= s_tdata[223:192];
				skip_q <= s_tuser[0] || !s_tuser[1] || !s_tuser[2] || fired_q;
				k_q    <= '0;
			end
			ST_CHK: begin
				if (outside)
					skip_q <= 1'b1;
				for (int i = 0; i < 3; i++)
					adc_q[i] <= adc_w[i][30:0];
			end
			ST_D1: d2_q <= p_q;
			ST_D2: d2_q <= d2_q + p_q;
			ST_D3: d2_q <= d2_q + p_q;
			ST_D4: r2_q <= p_q;
			ST_CMP: begin
				if (d2_q > r2_q)
					skip_q <= 1'b1;
				f_q <= (FRAC_BITS+1)'(1) << FRAC_BITS;
			end
			ST_FALL: if (div_done) f_q <= quot[FRAC_BITS:0];
			ST_MAG2: m_q <= p_q[FRAC_BITS +: 32];
			ST_SQRT: if (sq_done) d_q <= root[30:0];
			ST_FM:   fm_q <= '0;
			ST_FMW:  if (div_done) fm_q <= quot[31:0];
			ST_RES: begin
				res_q[k_q] <= sat32(sum_w);
				k_q        <= k_q + 2'd1;
			end
			ST_FIN: begin
				if (out_free) begin
					out_data_q <= {res_q[2], res_q[1], res_q[0]};
					out_user_q <= {!skip_q && impulse_mode_q, !skip_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

// ----- design/rff_checker.sv -----
// ----------------------------------------------------------------------------
// rff_checker
// Port-level checks for radial_force_field, bound to the top level.
// ----------------------------------------------------------------------------
module rff_checker
	import rff_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [95:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	// one body at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second request while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 96'd0 && !m_tuser[1])
		else $error("result not applied but fields nonzero");

	a_vel_applied: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("velocity flagged without applied");

endmodule

bind radial_force_field rff_checker u_rff_checker (.*);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for radial_force_field: drives rigid bodies over the
// slave stream, predicts force or impulse results in Q16.16 and compares
// every result on the master stream, across several field configurations.
// ----------------------------------------------------------------------------
module tb_top
	import rff_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] px, py, pz, vx, vy, vz, inv;
		logic        kin, awake, mpos;
	} body_t;

	typedef struct {
		logic        applied, is_vel;
		logic [31:0] ox, oy, oz;
	} force_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic [2:0]   cfg_addr = '0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [223:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [95:0]  m_tdata;
	logic [1:0]   m_tuser;

	radial_force_field u_dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// predictor state
	longint      fld_cx, fld_cy, fld_cz, fld_str;
	longint unsigned fld_rad;
	bit          fld_imp, fired;
	force_t      expected_forces[$];
	int          errors = 0;
	bit          drain_stall = 1;

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic longint unsigned mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned res = 0, b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic force_t field_force(body_t b);
		force_t o = '{default: 0};
		longint dc[3], vel[3];
		longint unsigned adc[3], r, r2, d2, d, f, m, rem, fm, dvm;
		bit neg;
		dc[0] = longint'($signed(b.px)) - fld_cx;
		dc[1] = longint'($signed(b.py)) - fld_cy;
		dc[2] = longint'($signed(b.pz)) - fld_cz;
		vel[0] = $signed(b.vx); vel[1] = $signed(b.vy); vel[2] = $signed(b.vz);
		if (b.kin || !b.awake || !b.mpos || fired) return o;
		r = fld_rad < RMIN_Q ? RMIN_Q : fld_rad;
		d2 = 0;
		for (int i = 0; i < 3; i++) begin
			adc[i] = mag(dc[i]);
			if (adc[i] > r) return o;
			d2 += adc[i] * adc[i];
		end
		r2 = r * r;
		if (d2 > r2) return o;
		if (d2 == 0) f = 64'd1 << FRAC_BITS;
		else begin
			rem = r2 - d2;
			f = 0;
			for (int i = 0; i < FRAC_BITS; i++) begin
				rem <<= 1;
				f <<= 1;
				if (rem >= r2) begin
					rem -= r2;
					f |= 1;
				end
			end
		end
		m = (mag(fld_str) * f) >> FRAC_BITS;
		d = root64(d2);
		o.applied = 1;
		o.is_vel = fld_imp;
		for (int i = 0; i < 3; i++) begin
			logic [31:0] v;
			fm = d != 0 ? (m * adc[i]) / d : 0;
			neg = (dc[i] < 0) != (fld_str < 0);
			if (fld_imp) begin
				dvm = (fm * b.inv) >> FRAC_BITS;
				v = clamp32(vel[i] + (neg ? -longint'(dvm) : longint'(dvm)));
			end else
				v = clamp32(neg ? -longint'(fm) : longint'(fm));
			if (i == 0) o.ox = v; else if (i == 1) o.oy = v; else o.oz = v;
		end
		if (fld_imp) fired = 1;
		return o;
	endfunction

	task automatic send_body(body_t b);
		int gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(posedge clk);
		s_tvalid <= 1;
		s_tdata <= {b.inv, b.vz, b.vy, b.vx, b.pz, b.py, b.px};
		s_tuser <= {b.mpos, b.awake, b.kin};
		do @(posedge clk); while (!s_tready);
		expected_forces.push_back(field_force(b));
		s_tvalid <= 0;
		// block is busy after accepting a request
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			force_t g, w;
			g.applied = m_tuser[0]; g.is_vel = m_tuser[1];
			g.ox = m_tdata[31:0]; g.oy = m_tdata[63:32]; g.oz = m_tdata[95:64];
			if (expected_forces.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				w = expected_forces.pop_front();
				if (g.applied !== w.applied) report("applied", g.applied, w.applied);
				if (g.is_vel !== w.is_vel) report("is_velocity", g.is_vel, w.is_vel);
				if (g.ox !== w.ox) report("out_x", g.ox, w.ox);
				if (g.oy !== w.oy) report("out_y", g.oy, w.oy);
				if (g.oz !== w.oz) report("out_z", g.oz, w.oz);
			end
		end
	end

	int ready_wait = 0;
	always @(posedge clk) begin
		if (ready_wait > 0) begin
			ready_wait <= ready_wait - 1;
			m_tready <= 0;
		end else if (m_tready && m_tvalid) begin
			if (drain_stall && $urandom_range(0, 3) != 0) begin
				ready_wait <= $urandom_range(1, 14);
				m_tready <= 0;
			end
		end else
			m_tready <= 1;
	end

	task automatic wait_drain();
		while (expected_forces.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_CENTER_X: fld_cx = longint'($signed(val));
			REG_CENTER_Y: fld_cy = longint'($signed(val));
			REG_CENTER_Z: fld_cz = longint'($signed(val));
			REG_RADIUS:   fld_rad = val[30:0];
			REG_STRENGTH: fld_str = longint'($signed(val));
			REG_IMPULSE:  fld_imp = val[0];
			default: ;
		endcase
	endtask

	task automatic set_field(logic [31:0] cx, cy, cz, rad, str, logic imp);
		wait_drain();
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_STRENGTH, str);
		write_reg(REG_IMPULSE, {31'd0, imp});
		cfg_we <= 0;
	endtask

	// position near the center, scaled to the radius so bodies land inside or just outside it
	function automatic body_t near_body(int span);
		body_t b;
		logic [31:0] sp = span;
		b.px = 32'(fld_cx + $signed($urandom_range(0, 2 * sp) - sp));
		b.py = 32'(fld_cy + $signed($urandom_range(0, 2 * sp) - sp));
		b.pz = 32'(fld_cz + $signed($urandom_range(0, 2 * sp) - sp));
		b.vx = $urandom; b.vy = $urandom; b.vz = $urandom;
		b.inv = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000);
		b.kin = $urandom_range(0, 9) == 0;
		b.awake = $urandom_range(0, 9) != 0;
		b.mpos = $urandom_range(0, 9) != 0;
		return b;
	endfunction

	function automatic body_t body_at(logic [31:0] x, y, z);
		body_t b = '{px: x, py: y, pz: z, vx: 32'h10000, vy: 32'h7FFFFFFF,
			vz: 32'h80000000, inv: 32'h10000, kin: 0, awake: 1, mpos: 1};
		return b;
	endfunction

	task automatic test_directed();
		body_t b;
		set_field(0, 0, 0, 32'h10000, 32'h10000, 0);
		send_body(body_at(0, 0, 0));              // zero distance
		send_body(body_at(32'h10000, 0, 0));      // on boundary
		send_body(body_at(32'h8000, 32'h4000, 32'hFFFF_C000));
		send_body(body_at(32'h20000, 0, 0));      // outside
		send_body(body_at(32'hC000, 32'hC000, 0)); // outside by distance
		send_body(body_at(32'h7FFFFFFF, 32'h80000000, 0));
		b = body_at(32'h8000, 0, 0); b.kin = 1; send_body(b);
		b.kin = 0; b.awake = 0; send_body(b);
		b.awake = 1; b.mpos = 0; send_body(b);
		set_field(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 0);
		send_body(body_at(32'h80000000, 32'h7FFFFFFF, 0));
		send_body(body_at(32'h7FFFFFFF, 32'h80000000, 32'h1000));
		send_body(body_at(32'h00000000, 32'h00000000, 32'h7FFFFFFF));
		set_field(0, 0, 0, 32'd1, 32'h7FFFFFFF, 0); // tiny radius
		send_body(body_at(32'd300, 32'd200, 0));
		send_body(body_at(32'd655, 0, 0));
		set_field(0, 0, 0, 32'h10000, 32'h80000000, 1);
		b = body_at(32'h100, 0, 0); b.inv = 32'hFFFFFFFF; send_body(b);
		send_body(body_at(32'h100, 0, 0));        // already fired
		set_field(0, 0, 0, 32'h10000, 32'h10000, 0);
		send_body(body_at(32'h100, 0, 0));        // fired even in continuous mode
	endtask

	task automatic test_random();
		int span;
		body_t b;
		for (int cfg = 0; cfg < 8; cfg++) begin
			logic [31:0] rad;
			rad = cfg == 0 ? 32'h7FFFFFFF : cfg == 1 ? 32'd655 : $urandom_range(1, 32'h1000000);
			set_field($urandom, $urandom, $urandom, rad,
				cfg == 2 ? 32'h7FFFFFFF : cfg == 3 ? 32'h80000000 : $urandom, 0);
			drain_stall = cfg != 4;
			span = rad[30:0] > 32'h3FFFFFFF ? 32'h3FFFFFFF : rad[30:0] + rad[30:0] / 4 + 1;
			for (int i = 0; i < 230; i++) begin
				b = $urandom_range(0, 9) == 0 ? body_at($urandom, $urandom, $urandom)
					: near_body(span);
				send_body(b);
			end
		end
		drain_stall = 1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		fld_cx = 0; fld_cy = 0; fld_cz = 0; fld_rad = 65536; fld_str = 65536;
		fld_imp = 0; fired = 0;
		@(posedge clk);
		// impulse fires once until reset, so it runs last
		test_random();
		test_directed();
		wait_drain();
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_forces.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end
endmodule

// ----- files.f -----
design/rff_pkg.sv
design/rff_mul.sv
design/rff_div.sv
design/rff_sqrt.sv
design/radial_force_field.sv
design/rff_checker.sv
verif/tb_top.sv
